// ===== rtl/gtsa_pkg.sv =====
package gtsa_pkg;

    // pool geometry
    localparam int PAGES = 4;
    localparam int SLOTS = 32;
    localparam int CELLS = PAGES * SLOTS;

    localparam int PAGE_IDX_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int PAGE_CNT_W = $clog2(PAGES + 1);
    localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CELL_W     = (CELLS > 1) ? $clog2(CELLS) : 1;

    // item field widths
    localparam int CMD_W    = 2;
    localparam int IN_PAGE_W = 2;
    localparam int IN_SLOT_W = 5;
    localparam int GEN_W    = 32;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 8;
    localparam int TOTAL_W  = 32;
    localparam int OPEN_W   = 3;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 128;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_STATS   = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_REJECT    = 2'd2
    } stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_READ,
        ST_UPDATE,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_clear;
        logic scan_step;
        logic take_free;
        logic open_page;
        logic exhaust;
        logic stats_clr;
        logic rel_reject;
        logic ram_rd;
        logic update;
        logic out_load;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic rel_in_range;
        logic scan_end;
        logic page_avail;
        logic scan_hit;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/gtsa_ram.sv =====
module gtsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/gtsa_ctrl.sv =====
module gtsa_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  gtsa_pkg::sts_t  sts,
    output gtsa_pkg::ctl_t  ctl
);

    gtsa_pkg::state_t state_reg;
    gtsa_pkg::state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gtsa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == gtsa_pkg::ST_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            gtsa_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    ctl.load   = 1'b1;
                    state_next = gtsa_pkg::ST_DECODE;
                end
            end
            gtsa_pkg::ST_DECODE: begin
                unique case (sts.cmd)
                    gtsa_pkg::CMD_ALLOC: begin
                        ctl.scan_clear = 1'b1;
                        state_next     = gtsa_pkg::ST_SCAN;
                    end
                    gtsa_pkg::CMD_RELEASE: begin
                        if (sts.rel_in_range) begin
                            state_next = gtsa_pkg::ST_READ;
                        end else begin
                            ctl.rel_reject = 1'b1;
                            state_next     = gtsa_pkg::ST_OUT;
                        end
                    end
                    gtsa_pkg::CMD_STATS: begin
                        ctl.stats_clr = 1'b1;
                        state_next    = gtsa_pkg::ST_OUT;
                    end
                    gtsa_pkg::CMD_NONE: begin
                        state_next = gtsa_pkg::ST_OUT;
                    end
                    default: begin
                        state_next = gtsa_pkg::ST_OUT;
                    end
                endcase
            end
            gtsa_pkg::ST_SCAN: begin
                priority if (sts.scan_end) begin
                    if (sts.page_avail) begin
                        ctl.open_page = 1'b1;
                        state_next    = gtsa_pkg::ST_READ;
                    end else begin
                        ctl.exhaust = 1'b1;
                        state_next  = gtsa_pkg::ST_OUT;
                    end
                end else if (sts.scan_hit) begin
                    ctl.take_free = 1'b1;
                    state_next    = gtsa_pkg::ST_READ;
                end else begin
                    ctl.scan_step = 1'b1;
                end
            end
            gtsa_pkg::ST_READ: begin
                ctl.ram_rd = 1'b1;
                state_next = gtsa_pkg::ST_UPDATE;
            end
            gtsa_pkg::ST_UPDATE: begin
                ctl.update = 1'b1;
                state_next = gtsa_pkg::ST_OUT;
            end
            gtsa_pkg::ST_OUT: begin
                if (sts.out_free) begin
                    ctl.out_load = 1'b1;
                    state_next   = gtsa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gtsa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/gtsa_dpath.sv =====
module gtsa_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [gtsa_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gtsa_pkg::M_DATA_W-1:0] m_tdata,
    input  gtsa_pkg::ctl_t                ctl,
    output gtsa_pkg::sts_t                sts
);

    localparam int PIW = gtsa_pkg::PAGE_IDX_W;
    localparam int PCW = gtsa_pkg::PAGE_CNT_W;
    localparam int SIW = gtsa_pkg::SLOT_IDX_W;
    localparam int CW  = gtsa_pkg::CELL_W;
    localparam int GW  = gtsa_pkg::GEN_W;
    localparam int NW  = gtsa_pkg::COUNT_W;
    localparam int TW  = gtsa_pkg::TOTAL_W;

    // item registers
    gtsa_pkg::cmd_t                     cmd_reg,       cmd_next;
    logic [gtsa_pkg::IN_PAGE_W-1:0]     rel_page_reg,  rel_page_next;
    logic [gtsa_pkg::IN_SLOT_W-1:0]     rel_slot_reg,  rel_slot_next;
    logic [GW-1:0]                      tag_reg,       tag_next;
    logic [PIW-1:0]                     cell_page_reg, cell_page_next;
    logic [SIW-1:0]                     cell_slot_reg, cell_slot_next;
    logic [PCW-1:0]                     scan_reg,      scan_next;

    // result registers
    gtsa_pkg::stat_t                    res_stat_reg,  res_stat_next;
    logic [PIW-1:0]                     res_page_reg,  res_page_next;
    logic [SIW-1:0]                     res_slot_reg,  res_slot_next;
    logic [GW-1:0]                      res_gen_reg,   res_gen_next;

    // allocator state
    logic [PCW-1:0]                     open_reg,      open_next;
    logic [NW-1:0]                      live_reg,      live_next;
    logic [NW-1:0]                      peak_reg,      peak_next;
    logic [TW-1:0]                      reuse_reg,     reuse_next;
    logic [TW-1:0]                      exh_reg,       exh_next;
    logic [gtsa_pkg::PAGES-1:0][gtsa_pkg::SLOTS-1:0] used_reg,  used_next;
    logic [gtsa_pkg::PAGES-1:0][gtsa_pkg::SLOTS-1:0] genv_reg,  genv_next;

    // output stage
    logic                               out_valid_reg, out_valid_next;
    logic [gtsa_pkg::M_DATA_W-1:0]      out_data_reg,  out_data_next;

    logic [gtsa_pkg::SLOTS-1:0]         scan_word;
    logic [SIW-1:0]                     free_slot;
    logic                               free_any;
    logic [CW-1:0]                      cell_addr;
    logic                               ram_we;
    logic [GW-1:0]                      ram_rdata;
    logic [GW-1:0]                      gen_cur;
    logic [GW-1:0]                      gen_new;
    logic [NW-1:0]                      live_inc;
    logic                               rel_match;

    // generation store
    gtsa_ram #(
        .WIDTH(GW),
        .DEPTH(gtsa_pkg::CELLS)
    ) u_gen_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cell_addr),
        .wdata (gen_new),
        .re    (ctl.ram_rd),
        .raddr (cell_addr),
        .rdata (ram_rdata)
    );

    assign cell_addr = CW'(cell_page_reg) * CW'(gtsa_pkg::SLOTS) + CW'(cell_slot_reg);

    // lowest free slot of the page under scan
    assign scan_word = used_reg[scan_reg[PIW-1:0]];
    always_comb begin
        free_slot = '0;
        free_any  = 1'b0;
        for (int i = gtsa_pkg::SLOTS - 1; i >= 0; i--) begin
            if (!scan_word[i]) begin
                free_slot = SIW'(i);
                free_any  = 1'b1;
            end
        end
    end

    // generation of the addressed cell, zero until first written
    assign gen_cur   = genv_reg[cell_page_reg][cell_slot_reg] ? ram_rdata : '0;
    assign gen_new   = gen_cur + GW'(1);
    assign live_inc  = (live_reg == {NW{1'b1}}) ? live_reg : live_reg + NW'(1);
    assign rel_match = used_reg[cell_page_reg][cell_slot_reg] && (gen_cur == tag_reg);
    assign ram_we    = ctl.update && (cmd_reg == gtsa_pkg::CMD_ALLOC);

    // status toward the controller
    always_comb begin
        sts.cmd          = cmd_reg;
        sts.rel_in_range = (32'(rel_page_reg) < 32'(open_reg))
                        && (32'(rel_slot_reg) < gtsa_pkg::SLOTS);
        sts.scan_end     = (scan_reg == open_reg);
        sts.page_avail   = (32'(open_reg) < gtsa_pkg::PAGES);
        sts.scan_hit     = free_any;
        sts.out_free     = !out_valid_reg || m_tready;
    end

    // next values
    always_comb begin
        cmd_next       = cmd_reg;
        rel_page_next  = rel_page_reg;
        rel_slot_next  = rel_slot_reg;
        tag_next       = tag_reg;
        cell_page_next = cell_page_reg;
        cell_slot_next = cell_slot_reg;
        scan_next      = scan_reg;
        res_stat_next  = res_stat_reg;
        res_page_next  = res_page_reg;
        res_slot_next  = res_slot_reg;
        res_gen_next   = res_gen_reg;
        open_next      = open_reg;
        live_next      = live_reg;
        peak_next      = peak_reg;
        reuse_next     = reuse_reg;
        exh_next       = exh_reg;
        used_next      = used_reg;
        genv_next      = genv_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // take the input beat
        if (ctl.load) begin
            cmd_next       = gtsa_pkg::cmd_t'(s_tdata[1:0]);
            rel_page_next  = s_tdata[3:2];
            rel_slot_next  = s_tdata[8:4];
            tag_next       = s_tdata[40:9];
            cell_page_next = PIW'(s_tdata[3:2]);
            cell_slot_next = SIW'(s_tdata[8:4]);
            res_stat_next  = gtsa_pkg::STAT_OK;
            res_page_next  = '0;
            res_slot_next  = '0;
            res_gen_next   = '0;
        end

        // page scan
        if (ctl.scan_clear) begin
            scan_next = '0;
        end
        if (ctl.scan_step) begin
            scan_next = scan_reg + PCW'(1);
        end
        if (ctl.take_free) begin
            cell_page_next = scan_reg[PIW-1:0];
            cell_slot_next = free_slot;
        end
        if (ctl.open_page) begin
            cell_page_next = open_reg[PIW-1:0];
            cell_slot_next = '0;
            open_next      = open_reg + PCW'(1);
        end
        if (ctl.exhaust) begin
            res_stat_next = gtsa_pkg::STAT_EXHAUSTED;
            if (exh_reg != {TW{1'b1}}) begin
                exh_next = exh_reg + TW'(1);
            end
        end

        // statistics reset and refused release
        if (ctl.stats_clr) begin
            reuse_next = '0;
            exh_next   = '0;
            peak_next  = live_reg;
        end
        if (ctl.rel_reject) begin
            res_stat_next = gtsa_pkg::STAT_REJECT;
        end

        // grant or free the addressed cell
        if (ctl.update) begin
            if (cmd_reg == gtsa_pkg::CMD_ALLOC) begin
                used_next[cell_page_reg][cell_slot_reg] = 1'b1;
                genv_next[cell_page_reg][cell_slot_reg] = 1'b1;
                live_next     = live_inc;
                peak_next     = (live_inc > peak_reg) ? live_inc : peak_reg;
                res_page_next = cell_page_reg;
                res_slot_next = cell_slot_reg;
                res_gen_next  = gen_new;
                if ((gen_new > GW'(1)) && (reuse_reg != {TW{1'b1}})) begin
                    reuse_next = reuse_reg + TW'(1);
                end
            end else if (rel_match) begin
                used_next[cell_page_reg][cell_slot_reg] = 1'b0;
                if (live_reg != '0) begin
                    live_next = live_reg - NW'(1);
                end
            end else begin
                res_stat_next = gtsa_pkg::STAT_REJECT;
            end
        end

        // output register
        if (ctl.out_load) begin
            out_valid_next          = 1'b1;
            out_data_next           = '0;
            out_data_next[1:0]      = res_stat_reg;
            out_data_next[3:2]      = gtsa_pkg::IN_PAGE_W'(res_page_reg);
            out_data_next[8:4]      = gtsa_pkg::IN_SLOT_W'(res_slot_reg);
            out_data_next[40:9]     = res_gen_reg;
            out_data_next[48:41]    = live_reg;
            out_data_next[56:49]    = peak_reg;
            out_data_next[88:57]    = reuse_reg;
            out_data_next[120:89]   = exh_reg;
            out_data_next[123:121]  = gtsa_pkg::OPEN_W'(open_reg);
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg      <= '0;
            live_reg      <= '0;
            peak_reg      <= '0;
            reuse_reg     <= '0;
            exh_reg       <= '0;
            used_reg      <= '0;
            genv_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            open_reg      <= open_next;
            live_reg      <= live_next;
            peak_reg      <= peak_next;
            reuse_reg     <= reuse_next;
            exh_reg       <= exh_next;
            used_reg      <= used_next;
            genv_reg      <= genv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        rel_page_reg  <= rel_page_next;
        rel_slot_reg  <= rel_slot_next;
        tag_reg       <= tag_next;
        cell_page_reg <= cell_page_next;
        cell_slot_reg <= cell_slot_next;
        scan_reg      <= scan_next;
        res_stat_reg  <= res_stat_next;
        res_page_reg  <= res_page_next;
        res_slot_reg  <= res_slot_next;
        res_gen_reg   <= res_gen_next;
        out_data_reg  <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/generation_tagged_slot_allocator_unit.sv =====
// flow from input beat to result beat: allocate decodes, scans the used map one word per
// open page up to the end of the open pages, opens a new page there if one is left, then
// reads (one registered read) and updates the generation memory, or goes to the output if
// refused; release reads and updates if in range; statistics and the unused command go to the output
// one command at a time: the input is held until the result is loaded into the output register
// reset: synchronous, clears maps, generation valid bits and counters at once
module generation_tagged_slot_allocator_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // command[1:0], page_index[3:2], slot_index[8:4], generation_tag[40:9]
    input  logic [gtsa_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[1:0], granted_page[3:2], granted_slot[8:4], granted_generation[40:9],
    // live_count[48:41], high_water[56:49], reuse_total[88:57],
    // exhaustion_total[120:89], pages_in_use[123:121]
    output logic [gtsa_pkg::M_DATA_W-1:0] m_tdata
);

    gtsa_pkg::ctl_t ctl;
    gtsa_pkg::sts_t sts;

    // sequencer
    gtsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // maps, generation store and counters
    gtsa_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .ctl      (ctl),
        .sts      (sts)
    );

endmodule
